@@ rtl/core/mppt_pkg.sv @@
// Shared types and constants for the perturb-and-observe duty tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package mppt_pkg;

  localparam int SAMPLE_W = 18;
  localparam int CURRENT_W = 16;
  localparam int VOLT_W = 17;
  localparam int AMP_W = 15;
  localparam int POWER_W = 32;
  localparam int OCUR_W = 16;
  localparam int CFG_W = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int DUTY_OUT_W = 16;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 24;

  localparam logic [VOLT_W-1:0] TRIP_VOLTS = 17'd28800;
  localparam logic [VOLT_W-1:0] READY_VOLTS = 17'd22400;
  localparam logic [VOLT_W-1:0] STAGE_VOLTS = 17'd20480;
  localparam logic [VOLT_W-1:0] ARM_VOLTS = 17'd16000;

  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_STEP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAXIMUM = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MINIMUM = 3'd5;

  localparam logic [VOLT_W-1:0] BATTERY_LIMIT_RESET = 17'd1792;
  localparam logic [OCUR_W-1:0] CURRENT_LIMIT_RESET = 16'd7680;
  localparam logic [VOLT_W-1:0] VOLTAGE_LIMIT_RESET = 17'd20800;
  localparam logic [15:0] DUTY_STEP_RESET = 16'd197;
  localparam logic [15:0] DUTY_MAXIMUM_RESET = 16'd39322;
  localparam logic [15:0] DUTY_MINIMUM_RESET = 16'd13107;

  typedef struct packed {
    logic [VOLT_W-1:0] battery_limit;
    logic [OCUR_W-1:0] current_limit;
    logic [VOLT_W-1:0] voltage_limit;
    logic [15:0] duty_step;
    logic [15:0] duty_maximum;
    logic [15:0] duty_minimum;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_start;
    logic cur;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/mppt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath for the output current estimate.
module mppt_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  busy,
  output logic                  done
);

  localparam int CW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [CW-1:0] cnt;
  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
      cnt <= CW'(DIVIDEND_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

@@ rtl/core/mppt_ctrl.sv @@
// Sequencing state machine for one sample: capture, multiply, divide, output current, update.
// Uses mppt_pkg for the command and status structs.
module mppt_ctrl
  import mppt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_CUR = 3'd4;
  localparam logic [2:0] ST_UPD = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          state_next = ST_CUR;
        end
      end
      ST_CUR: begin
        cmd.cur = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_WAIT)
    else $error("divider finished outside the wait state");

endmodule

@@ rtl/core/mppt_dp.sv @@
// Datapath: sample averaging, power product, current estimate, duty tracking
// and the output register. Uses mppt_pkg and instantiates mppt_div.
module mppt_dp
  import mppt_pkg::*;
#(
  parameter int DUTY_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  cfg_t                  cfg,
  input  logic [SAMPLE_W-1:0]   array_voltage,
  input  logic [CURRENT_W-1:0]  array_current,
  input  logic [SAMPLE_W-1:0]   output_voltage,
  input  logic [SAMPLE_W-1:0]   battery_voltage,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_OUT_W-1:0] duty_ratio,
  output logic                  high_output_trip,
  output logic                  output_ready,
  output logic                  battery_high
);

  localparam int SW = ((DUTY_WIDTH > 16) ? DUTY_WIDTH : 16) + 2;
  localparam logic [DUTY_WIDTH-1:0] DUTY_RESET =
    DUTY_WIDTH'(((64'd3 << DUTY_WIDTH) + 64'd5) / 64'd10);

  logic [VOLT_W-1:0] va;
  logic [AMP_W-1:0] ia;
  logic [VOLT_W-1:0] vo;
  logic [VOLT_W-1:0] vb;
  logic [POWER_W-1:0] pa;
  logic [POWER_W-1:0] prod;
  logic [OCUR_W-1:0] oc;
  logic [VOLT_W-1:0] tracked_voltage;
  logic [POWER_W-1:0] tracked_power;
  logic [DUTY_WIDTH-1:0] duty_value;
  logic tracking_enabled;
  logic ready_armed;
  logic ready_stage;
  logic ready_latch;
  logic battery_flag;

  logic [VOLT_W-1:0] av_c;
  logic [AMP_W-1:0] ac_c;
  logic [VOLT_W-1:0] ov_c;
  logic [VOLT_W-1:0] bv_c;
  logic [VOLT_W:0] va_sum;
  logic [AMP_W:0] ia_sum;
  logic [VOLT_W:0] vo_sum;
  logic [VOLT_W:0] vb_sum;

  logic [POWER_W-1:0] quo;
  logic div_busy;
  logic div_done;
  logic [OCUR_W-1:0] q_sat;
  logic [OCUR_W-1:0] oc_raw;
  logic [OCUR_W:0] oc_sum;

  logic tracking_next;
  logic armed_next;
  logic stage_next;
  logic latch_next;
  logic battery_next;
  logic step_up;
  logic step_down;
  logic signed [SW-1:0] d_cur;
  logic signed [SW-1:0] d_step;
  logic signed [SW-1:0] d_new;
  logic signed [SW-1:0] d_max;
  logic signed [SW-1:0] d_min;
  logic signed [SW-1:0] d_clamp;

  assign av_c = array_voltage[SAMPLE_W-1] ? '0 : array_voltage[VOLT_W-1:0];
  assign ac_c = array_current[CURRENT_W-1] ? '0 : array_current[AMP_W-1:0];
  assign ov_c = output_voltage[SAMPLE_W-1] ? '0 : output_voltage[VOLT_W-1:0];
  assign bv_c = battery_voltage[SAMPLE_W-1] ? '0 : battery_voltage[VOLT_W-1:0];
  assign va_sum = {1'b0, av_c} + {1'b0, va};
  assign ia_sum = {1'b0, ac_c} + {1'b0, ia};
  assign vo_sum = {1'b0, ov_c} + {1'b0, vo};
  assign vb_sum = {1'b0, bv_c} + {1'b0, vb};

  assign prod = va * ia;

  mppt_div #(
    .DIVIDEND_W(POWER_W),
    .DIVISOR_W (VOLT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(pa),
    .divisor (vo),
    .quotient(quo),
    .busy    (div_busy),
    .done    (div_done)
  );

  assign q_sat = (|quo[POWER_W-1:OCUR_W]) ? '1 : quo[OCUR_W-1:0];
  assign oc_raw = (vo != '0) ? q_sat : oc;
  assign oc_sum = {1'b0, oc_raw} + {1'b0, oc};

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  assign tracking_next = tracking_enabled || (vo > TRIP_VOLTS);
  assign armed_next = ready_armed || ((va > ARM_VOLTS) && tracking_next);
  assign stage_next = ready_stage || (armed_next && (vo > STAGE_VOLTS));
  assign latch_next = ready_latch || ((vo > READY_VOLTS) && ready_stage);

  always_comb begin
    battery_next = battery_flag;
    if (vb > cfg.battery_limit) begin
      battery_next = 1'b1;
    end else if (vb < cfg.battery_limit) begin
      battery_next = 1'b0;
    end
  end

  always_comb begin
    step_up = 1'b0;
    step_down = 1'b0;
    if (tracking_next) begin
      priority if (oc > cfg.current_limit || vo > cfg.voltage_limit) begin
        step_down = 1'b1;
      end else if (pa > tracked_power && va > tracked_voltage) begin
        step_down = 1'b1;
      end else if (pa > tracked_power && va < tracked_voltage) begin
        step_up = 1'b1;
      end else if (pa < tracked_power && va > tracked_voltage) begin
        step_up = 1'b1;
      end else if (pa < tracked_power && va < tracked_voltage) begin
        step_down = 1'b1;
      end else if (vo < cfg.voltage_limit) begin
        step_up = 1'b1;
      end
    end
  end

  assign d_cur = $signed(SW'(duty_value));
  assign d_step = $signed(SW'(cfg.duty_step));
  assign d_max = $signed(SW'(cfg.duty_maximum));
  assign d_min = $signed(SW'(cfg.duty_minimum));

  always_comb begin
    d_new = d_cur;
    if (step_up) begin
      d_new = d_cur + d_step;
    end else if (step_down) begin
      d_new = d_cur - d_step;
    end
    priority if (d_new > d_max) begin
      d_clamp = d_max;
    end else if (d_new < d_min) begin
      d_clamp = d_min;
    end else begin
      d_clamp = d_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
      ia <= '0;
      vo <= '0;
      vb <= '0;
      oc <= '0;
      tracked_voltage <= '0;
      tracked_power <= '0;
      duty_value <= DUTY_RESET;
      tracking_enabled <= 1'b0;
      ready_armed <= 1'b0;
      ready_stage <= 1'b0;
      ready_latch <= 1'b0;
      battery_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        va <= va_sum[VOLT_W:1];
        ia <= ia_sum[AMP_W:1];
        vo <= vo_sum[VOLT_W:1];
        vb <= vb_sum[VOLT_W:1];
      end
      if (cmd.cur) begin
        oc <= oc_sum[OCUR_W:1];
      end
      if (cmd.update) begin
        tracking_enabled <= tracking_next;
        ready_armed <= armed_next;
        ready_stage <= stage_next;
        ready_latch <= latch_next;
        battery_flag <= battery_next;
        duty_value <= DUTY_WIDTH'(d_clamp);
        if (tracking_next && !(oc > cfg.current_limit || vo > cfg.voltage_limit)) begin
          tracked_voltage <= va;
          tracked_power <= pa;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa <= prod;
    end
    if (cmd.update) begin
      duty_ratio <= DUTY_OUT_W'(DUTY_WIDTH'(d_clamp));
      high_output_trip <= tracking_next;
      output_ready <= latch_next;
      battery_high <= battery_next;
    end
  end

  a_trip_holds: assert property (@(posedge clk) disable iff (rst)
    tracking_enabled |=> tracking_enabled)
    else $error("run flag cleared without reset");
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    ready_latch |=> ready_latch)
    else $error("ready latch cleared without reset");
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture || cmd.update) |-> !div_busy)
    else $error("state changed while the divider was running");

endmodule

@@ rtl/core/mppt_perturb_observe_duty_top.sv @@
// Top level of the perturb-and-observe duty tracker: stream ports, register
// file and the controller/datapath pair. Uses mppt_pkg, mppt_ctrl, mppt_dp.
//
// Channel   Direction  Contents
// s_axis    in         one sample: array, output and battery voltage, current
// m_axis    out        one result per sample: duty ratio and status flags
// cfg       in         register writes, one per cycle, no read-back
//
// A request passes capture, the power product, the 32-step divider that forms
// the output current estimate, the current average and the duty update.
// Once its result is loaded the controller is idle and can take a new request,
// even while that result still waits on m_axis_tready; a result that is not taken
// stalls the following request in its final step.
// rst is synchronous and active high; it restores all register defaults.
module mppt_perturb_observe_duty_top
  import mppt_pkg::*;
#(
  parameter int DUTY_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // array_voltage[17:0], array_current[33:18], output_voltage[51:34],
  // battery_voltage[69:52], zero pad[71:70]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // duty_ratio[15:0], high_output_trip[16], output_ready[17],
  // battery_high[18], zero pad[23:19]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam logic [15:0] DUTY_CFG_MASK =
    (DUTY_WIDTH >= 16) ? 16'hFFFF : 16'((64'd1 << DUTY_WIDTH) - 64'd1);

  cfg_t cfg;
  cmd_t cmd;
  status_t status;
  logic [DUTY_OUT_W-1:0] duty_ratio;
  logic high_output_trip;
  logic output_ready;
  logic battery_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_limit <= BATTERY_LIMIT_RESET;
      cfg.current_limit <= CURRENT_LIMIT_RESET;
      cfg.voltage_limit <= VOLTAGE_LIMIT_RESET;
      cfg.duty_step <= DUTY_STEP_RESET & DUTY_CFG_MASK;
      cfg.duty_maximum <= DUTY_MAXIMUM_RESET & DUTY_CFG_MASK;
      cfg.duty_minimum <= DUTY_MINIMUM_RESET & DUTY_CFG_MASK;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BATTERY_LIMIT: cfg.battery_limit <= cfg_data;
        REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data[15:0];
        REG_VOLTAGE_LIMIT: cfg.voltage_limit <= cfg_data;
        REG_DUTY_STEP:     cfg.duty_step <= cfg_data[15:0] & DUTY_CFG_MASK;
        REG_DUTY_MAXIMUM:  cfg.duty_maximum <= cfg_data[15:0] & DUTY_CFG_MASK;
        REG_DUTY_MINIMUM:  cfg.duty_minimum <= cfg_data[15:0] & DUTY_CFG_MASK;
        default: begin
        end
      endcase
    end
  end

  mppt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  mppt_dp #(
    .DUTY_WIDTH(DUTY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .array_voltage   (s_axis_tdata[17:0]),
    .array_current   (s_axis_tdata[33:18]),
    .output_voltage  (s_axis_tdata[51:34]),
    .battery_voltage (s_axis_tdata[69:52]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .duty_ratio      (duty_ratio),
    .high_output_trip(high_output_trip),
    .output_ready    (output_ready),
    .battery_high    (battery_high)
  );

  assign m_axis_tdata = {5'b0, battery_high, output_ready, high_output_trip, duty_ratio};

endmodule
